// ----- hdl/imfe_pkg.sv -----
// Shared types, constants and decode functions for the ITCH message field extractor.
// No dependencies; all files but imfe_queue refer to it by scoped names.

package imfe_pkg;

	localparam int CLASS_W = 13;
	localparam logic [CLASS_W-1:0] CLASS_ENABLE_RESET = 13'h1FFF;
	localparam int QUEUE_DEPTH = 2;
	localparam int POS_W = 17;

	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_B = 8'h42;
	localparam logic [7:0] CHAR_F = 8'h46;
	localparam logic [7:0] CHAR_S = 8'h53;

	typedef enum logic [3:0] {
		CLS_SYS_EVENT = 4'd0,
		CLS_STOCK_DIR = 4'd1,
		CLS_TRADING   = 4'd2,
		CLS_REG_SHO   = 4'd3,
		CLS_PARTIC    = 4'd4,
		CLS_MWCB      = 4'd5,
		CLS_IPO       = 4'd6,
		CLS_LULD      = 4'd7,
		CLS_ORDER     = 4'd8,
		CLS_MODIFY    = 4'd9,
		CLS_TRADE     = 4'd10,
		CLS_NOII      = 4'd11,
		CLS_RPII      = 4'd12,
		CLS_NONE      = 4'd13
	} class_e;

	typedef enum logic [3:0] {
		SLOT_HDR,
		SLOT_TIME,
		SLOT_REF,
		SLOT_SIDE,
		SLOT_SHARES,
		SLOT_SYMBOL,
		SLOT_PRICE,
		SLOT_MPID,
		SLOT_NONE
	} slot_e;

	typedef struct packed {
		logic [31:0] hdr;
		logic [47:0] stamp;
		logic [63:0] ref_num;
		logic [7:0]  side;
		logic [31:0] shares;
		logic [63:0] symbol;
		logic [31:0] price;
		logic [31:0] mpid;
	} cap_t;

	typedef struct packed {
		logic        unknown;
		logic [7:0]  type_char;
		cap_t        cap;
	} rec_entry_t;

	localparam int ENTRY_W = $bits(rec_entry_t);

	// message body length by type byte, zero when the type is not known
	function automatic logic [7:0] size_lookup(input logic [7:0] t);
		logic [7:0] sz;
		case (t)
			8'h41: sz = 8'd36;
			8'h42: sz = 8'd19;
			8'h43: sz = 8'd36;
			8'h44: sz = 8'd19;
			8'h45: sz = 8'd31;
			8'h46: sz = 8'd40;
			8'h48: sz = 8'd25;
			8'h49: sz = 8'd50;
			8'h4A: sz = 8'd35;
			8'h4B: sz = 8'd28;
			8'h4C: sz = 8'd26;
			8'h4E: sz = 8'd20;
			8'h50: sz = 8'd44;
			8'h51: sz = 8'd40;
			8'h52: sz = 8'd39;
			8'h53: sz = 8'd12;
			8'h55: sz = 8'd35;
			8'h56: sz = 8'd35;
			8'h57: sz = 8'd12;
			8'h58: sz = 8'd23;
			8'h59: sz = 8'd20;
			8'h68: sz = 8'd21;
			default: sz = 8'd0;
		endcase
		return sz;
	endfunction

	function automatic class_e class_lookup(input logic [7:0] t);
		class_e c;
		case (t)
			8'h53:               c = CLS_SYS_EVENT;
			8'h52:               c = CLS_STOCK_DIR;
			8'h48, 8'h68:        c = CLS_TRADING;
			8'h59:               c = CLS_REG_SHO;
			8'h4C:               c = CLS_PARTIC;
			8'h56, 8'h57:        c = CLS_MWCB;
			8'h4B:               c = CLS_IPO;
			8'h4A:               c = CLS_LULD;
			8'h41, 8'h46:        c = CLS_ORDER;
			8'h45, 8'h43, 8'h58,
			8'h44, 8'h55:        c = CLS_MODIFY;
			8'h50, 8'h51, 8'h42: c = CLS_TRADE;
			8'h49:               c = CLS_NOII;
			8'h4E:               c = CLS_RPII;
			default:             c = CLS_NONE;
		endcase
		return c;
	endfunction

	// capture slot for a message byte index (type byte is index 0)
	function automatic slot_e slot_lookup(input logic [POS_W-1:0] idx);
		slot_e s;
		if (idx inside {[1:4]}) begin
			s = SLOT_HDR;
		end else if (idx inside {[5:10]}) begin
			s = SLOT_TIME;
		end else if (idx inside {[11:18]}) begin
			s = SLOT_REF;
		end else if (idx == 19) begin
			s = SLOT_SIDE;
		end else if (idx inside {[20:23]}) begin
			s = SLOT_SHARES;
		end else if (idx inside {[24:31]}) begin
			s = SLOT_SYMBOL;
		end else if (idx inside {[32:35]}) begin
			s = SLOT_PRICE;
		end else if (idx inside {[36:39]}) begin
			s = SLOT_MPID;
		end else begin
			s = SLOT_NONE;
		end
		return s;
	endfunction

endpackage

// ----- hdl/imfe_if.sv -----
// Channel interfaces of the ITCH message field extractor: byte feed, config write, result.
// Depends on imfe_pkg for the class-enable width.

interface imfe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface imfe_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [imfe_pkg::CLASS_W-1:0] class_enable;

	modport source (output valid, output class_enable, input ready);
	modport sink (input valid, input class_enable, output ready);
endinterface

interface imfe_result_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [7:0]  message_type;
	logic [15:0] locate_code;
	logic [15:0] tracking_id;
	logic [47:0] time_stamp;
	logic [7:0]  system_event;
	logic [63:0] order_number;
	logic        buy_side;
	logic [31:0] share_count;
	logic [63:0] symbol_bytes;
	logic [31:0] price_ticks;
	logic [31:0] participant_id;

	modport source (
		output valid, output status, output message_type, output locate_code,
		output tracking_id, output time_stamp, output system_event,
		output order_number, output buy_side, output share_count,
		output symbol_bytes, output price_ticks, output participant_id,
		input ready
	);
	modport sink (
		input valid, input status, input message_type, input locate_code,
		input tracking_id, input time_stamp, input system_event,
		input order_number, input buy_side, input share_count,
		input symbol_bytes, input price_ticks, input participant_id,
		output ready
	);
endinterface

// ----- hdl/itch_message_field_extractor_top.sv -----
// Top level of the ITCH message field extractor: front end, record queue, back end.
// Depends on imfe_pkg, imfe_if, imfe_front, imfe_queue and imfe_back.
//
// Usage:
//   feed   - record stream, one byte per transfer: 2-byte big-endian length prefix,
//            then the message starting with its type byte.
//   cfg    - class_enable write, always ready; write only while the block is idle.
//   result - one transfer per record of an enabled class, or per unknown type
//            (status 1, all fields but message_type zero). Disabled classes give none.
// Throughput: one byte per clock while the queue has room. Known types are framed
//   by the type table, unknown types by the prefix.
// Path: the queue is written at the transfer of the record's last byte; the back end
//   then pops it into the output register, which drives result.valid, once that
//   register is empty or its result is being taken.
// Stall: records wait in a queue of QUEUE_DEPTH entries behind the output register;
//   feed.ready drops only while that queue is full.
// Reset: byte position returns to the first prefix byte, queue and output empty,
//   class_enable back to all ones.

module itch_message_field_extractor_top #(
	parameter int QUEUE_DEPTH = imfe_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	imfe_byte_if.sink     feed,
	imfe_cfg_if.sink      cfg,
	imfe_result_if.source result
);

	logic                         q_push;
	logic                         q_pop;
	logic                         q_full;
	logic                         q_empty;
	imfe_pkg::rec_entry_t         q_wdata;
	logic [imfe_pkg::ENTRY_W-1:0] q_rdata;

	imfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed       (feed),
		.cfg        (cfg),
		.q_full     (q_full),
		.push       (q_push),
		.push_entry (q_wdata)
	);

	imfe_queue #(
		.WIDTH (imfe_pkg::ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.full      (q_full),
		.empty     (q_empty)
	);

	imfe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.pop     (q_pop),
		.result  (result)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("record pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("record popped from an empty queue");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status) |->
		(result.locate_code == '0 && result.tracking_id == '0 &&
		 result.time_stamp == '0 && result.order_number == '0 &&
		 result.symbol_bytes == '0 && result.participant_id == '0))
		else $error("unknown-type result carries field data");

	a_mpid_only_f: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.message_type != imfe_pkg::CHAR_F) |->
		(result.participant_id == '0))
		else $error("participant id on a non-F result");

	a_pop_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> result.valid)
		else $error("popped record did not reach the output register");

endmodule

// ----- hdl/imfe_front.sv -----
// Front end: framing, field capture and class filtering, one byte per clock unless
// the queue is full. Uses imfe_pkg and imfe_if; pushes finished records into it.

module imfe_front (
	input  logic                     clk,
	input  logic                     arst_n,
	imfe_byte_if.sink                feed,
	imfe_cfg_if.sink                 cfg,
	input  logic                     q_full,
	output logic                     push,
	output imfe_pkg::rec_entry_t     push_entry
);

	localparam int PW = imfe_pkg::POS_W;

	logic [PW-1:0]                  pos_q;
	logic [PW-1:0]                  last_q;
	logic [15:0]                    prefix_q;
	logic [7:0]                     type_q;
	logic                           unknown_q;
	imfe_pkg::cap_t                 cap_q;
	logic [imfe_pkg::CLASS_W-1:0]   class_enable_q;

	logic                           acc;
	logic [7:0]                     b;
	logic                           at_type;
	logic [7:0]                     size_raw;
	logic [PW-1:0]                  len_body;
	logic [PW-1:0]                  last_n;
	logic [7:0]                     type_n;
	logic                           unknown_n;
	logic                           end_rec;
	logic                           emit;
	imfe_pkg::class_e               cls;
	imfe_pkg::slot_e                slot;
	imfe_pkg::cap_t                 cap_n;

	assign feed.ready = !q_full;
	assign cfg.ready  = 1'b1;
	assign acc        = feed.valid && feed.ready;
	assign b          = feed.data_byte;
	assign at_type    = (pos_q == PW'(2));

	always_comb begin
		size_raw  = imfe_pkg::size_lookup(b);
		unknown_n = at_type ? (size_raw == 8'd0) : unknown_q;
		type_n    = at_type ? b : type_q;
		if (size_raw != 8'd0) begin
			len_body = PW'(size_raw);
		end else if (prefix_q == 16'd0) begin
			len_body = PW'(1);
		end else begin
			len_body = PW'(prefix_q);
		end
		last_n = len_body + PW'(1);

		if (at_type) begin
			end_rec = (last_n == PW'(2));
		end else begin
			end_rec = (pos_q >= PW'(3)) && (pos_q == last_q);
		end

		cls  = imfe_pkg::class_lookup(type_n);
		emit = unknown_n || ((cls != imfe_pkg::CLS_NONE) && class_enable_q[cls]);
		push = acc && end_rec && emit;

		slot  = imfe_pkg::slot_lookup(pos_q - PW'(2));
		cap_n = cap_q;
		if (at_type) begin
			cap_n = '0;
		end else if (pos_q >= PW'(3)) begin
			case (slot)
				imfe_pkg::SLOT_HDR:    cap_n.hdr     = {cap_q.hdr[23:0], b};
				imfe_pkg::SLOT_TIME:   cap_n.stamp   = {cap_q.stamp[39:0], b};
				imfe_pkg::SLOT_REF:    cap_n.ref_num = {cap_q.ref_num[55:0], b};
				imfe_pkg::SLOT_SIDE:   cap_n.side    = b;
				imfe_pkg::SLOT_SHARES: cap_n.shares  = {cap_q.shares[23:0], b};
				imfe_pkg::SLOT_SYMBOL: cap_n.symbol  = {cap_q.symbol[55:0], b};
				imfe_pkg::SLOT_PRICE:  cap_n.price   = {cap_q.price[23:0], b};
				imfe_pkg::SLOT_MPID:   cap_n.mpid    = {cap_q.mpid[23:0], b};
				default: ;
			endcase
		end

		push_entry.unknown   = unknown_n;
		push_entry.type_char = type_n;
		push_entry.cap       = cap_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			class_enable_q <= imfe_pkg::CLASS_ENABLE_RESET;
		end else begin
			if (cfg.valid && cfg.ready) begin
				class_enable_q <= cfg.class_enable;
			end
			if (acc) begin
				if (end_rec) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + PW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cap_q <= cap_n;
			case (pos_q)
				PW'(0): prefix_q[15:8] <= b;
				PW'(1): prefix_q[7:0]  <= b;
				PW'(2): begin
					type_q    <= b;
					unknown_q <= unknown_n;
					last_q    <= last_n;
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- hdl/imfe_queue.sv -----
// Short register queue between front and back end.
// No package dependency; width and depth come from the parent.

module imfe_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- hdl/imfe_back.sv -----
// Back end: pops records, formats the result fields per type, holds the output register.
// Depends on imfe_pkg and imfe_if.

module imfe_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  logic [imfe_pkg::ENTRY_W-1:0] q_data,
	output logic                         pop,
	imfe_result_if.source                result
);

	imfe_pkg::rec_entry_t e;
	logic                 valid_q;
	logic                 is_order;

	assign e            = q_data;
	assign pop          = !q_empty && (!valid_q || result.ready);
	assign result.valid = valid_q;
	assign is_order     = (e.type_char == imfe_pkg::CHAR_A) || (e.type_char == imfe_pkg::CHAR_F);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result.status          <= e.unknown;
			result.message_type    <= e.type_char;
			result.locate_code     <= '0;
			result.tracking_id     <= '0;
			result.time_stamp      <= '0;
			result.system_event    <= '0;
			result.order_number    <= '0;
			result.buy_side        <= 1'b0;
			result.share_count     <= '0;
			result.symbol_bytes    <= '0;
			result.price_ticks     <= '0;
			result.participant_id  <= '0;
			if (!e.unknown) begin
				result.locate_code <= e.cap.hdr[31:16];
				result.tracking_id <= e.cap.hdr[15:0];
				result.time_stamp  <= e.cap.stamp;
				if (e.type_char == imfe_pkg::CHAR_S) begin
					result.system_event <= e.cap.ref_num[7:0];
				end
				if (is_order) begin
					result.order_number <= e.cap.ref_num;
					result.buy_side     <= (e.cap.side == imfe_pkg::CHAR_B);
					result.share_count  <= e.cap.shares;
					result.symbol_bytes <= e.cap.symbol;
					result.price_ticks  <= e.cap.price;
					if (e.type_char == imfe_pkg::CHAR_F) begin
						result.participant_id <= e.cap.mpid;
					end
				end
			end
		end
	end

endmodule
